/* hw/rtl/spt_pkg.sv */
package spt_pkg;

    localparam int MAX_ENTRIES    = 64;
    localparam int NUM_BANKS      = 4;
    localparam int TILES_PER_BANK = 256;

    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int OP_W    = 2;
    localparam int BANK_W  = 8;
    localparam int TILE_W  = 8;
    localparam int ENTRY_W = 7;

    localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET    = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_TOGGLE = 2'd3;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [BANK_W-1:0] bank_t;
    typedef logic [TILE_W-1:0] tile_t;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic  sample;   // latch compare result for the incoming pair
        logic  add;      // write the pair into the first free cell
        logic  remove;   // close the gap at slot by pulling from the neighbor
        idx_t  slot;     // cell that holds the matching pair
        cnt_t  count;    // number of occupied cells
        bank_t bank;
        tile_t tile;
    } cell_ctl_t;

endpackage

/* hw/rtl/spt_if.sv */
interface spt_req_if;
    import spt_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BANK_W-1:0] bank;
    logic [TILE_W-1:0] tile;

    modport source (output valid, output operation, output bank, output tile, input ready);
    modport sink   (input valid, input operation, input bank, input tile, output ready);
endinterface

interface spt_rsp_if;
    import spt_pkg::*;

    logic               valid;
    logic               ready;
    logic               answer;
    logic               full_reject;
    logic [ENTRY_W-1:0] entry_count;

    modport source (output valid, output answer, output full_reject, output entry_count,
                    input ready);
    modport sink   (input valid, input answer, input full_reject, input entry_count,
                    output ready);
endinterface

/* hw/rtl/spt_cell.sv */
module spt_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  spt_pkg::idx_t     idx,
    input  spt_pkg::cell_ctl_t ctl,
    input  spt_pkg::bank_t    nb_bank,
    input  spt_pkg::tile_t    nb_tile,
    output spt_pkg::bank_t    bank,
    output spt_pkg::tile_t    tile,
    output logic              hit
);
    import spt_pkg::*;

    bank_t bank_reg;
    tile_t tile_reg;
    logic  hit_reg;
    logic  hit_next;
    logic  occupied;
    logic  load;
    logic  shift;

    assign occupied = CNT_W'(idx) < ctl.count;
    assign hit_next = occupied && (bank_reg == ctl.bank) && (tile_reg == ctl.tile);
    assign load     = ctl.add && (CNT_W'(idx) == ctl.count);
    assign shift    = ctl.remove && (idx >= ctl.slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.sample)
        begin
            hit_reg <= hit_next;
        end
    end

    // Payload: no reset, contents beyond the count are never compared
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bank_reg <= ctl.bank;
            tile_reg <= ctl.tile;
        end
        else if (shift)
        begin
            bank_reg <= nb_bank;
            tile_reg <= nb_tile;
        end
    end

    assign bank = bank_reg;
    assign tile = tile_reg;
    assign hit  = hit_reg;
endmodule

/* hw/rtl/solid_pattern_set_table.sv */
// A request is taken while the block is idle; the cells latch their compare results
// as it is taken, and the response is registered when the row is updated.
// One request at a time: the compare pass over the cell row and the update of
// the row complete before the next request is taken.
// A response held by the sink delays the update and the next request.
// Reset: asynchronous, clears the pair count and control; the set is empty
// and the block is ready for a request out of reset.
module solid_pattern_set_table (
    input  logic          clk,
    input  logic          rst_n,
    spt_req_if.sink       req,
    spt_rsp_if.source     rsp
);
    import spt_pkg::*;

    logic                  busy_reg;
    logic [OP_W-1:0]       op_reg;
    logic                  pair_ok_reg;
    bank_t                 bank_reg;
    tile_t                 tile_reg;
    cnt_t                  count_reg;
    cnt_t                  count_next;
    logic                  out_valid_reg;
    logic                  answer_reg;
    logic                  answer_next;
    logic                  reject_reg;
    logic                  reject_next;
    logic [ENTRY_W-1:0]    entry_reg;

    logic                  accept;
    logic                  finish;
    logic                  pair_ok;
    logic                  any_hit;
    logic                  want_on;
    logic                  do_add;
    logic                  do_remove;
    idx_t                  slot;
    cell_ctl_t             ctl;

    logic  [MAX_ENTRIES-1:0] hit_vec;
    bank_t                   cell_bank [MAX_ENTRIES];
    tile_t                   cell_tile [MAX_ENTRIES];

    assign accept  = req.valid && req.ready;
    assign finish  = busy_reg && (!out_valid_reg || rsp.ready);
    assign pair_ok = ({1'b0, req.bank} < 9'(NUM_BANKS)) &&
                     ({1'b0, req.tile} < 9'(TILES_PER_BANK));

    // Matches are unique, so OR the indices of hit cells to encode the slot
    always_comb
    begin
        slot = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            slot = slot | ({IDX_W{hit_vec[i]}} & IDX_W'(i));
        end
    end

    assign any_hit = |hit_vec;

    always_comb
    begin
        want_on     = 1'b0;
        do_add      = 1'b0;
        do_remove   = 1'b0;
        answer_next = 1'b0;
        reject_next = 1'b0;
        count_next  = count_reg;
        unique case (op_reg)
            OP_QUERY:  want_on = 1'b0;
            OP_SET:    want_on = 1'b1;
            OP_CLEAR:  want_on = 1'b0;
            OP_TOGGLE: want_on = !any_hit;
            default:   want_on = 1'b0;
        endcase
        if (!pair_ok_reg)
        begin
            answer_next = 1'b0;
        end
        else if (op_reg == OP_QUERY)
        begin
            answer_next = any_hit;
        end
        else if (any_hit)
        begin
            if (want_on)
            begin
                answer_next = 1'b1;
            end
            else
            begin
                do_remove  = 1'b1;
                count_next = count_reg - CNT_W'(1);
            end
        end
        else if (want_on)
        begin
            if (count_reg >= CNT_W'(MAX_ENTRIES))
            begin
                reject_next = 1'b1;
            end
            else
            begin
                do_add      = 1'b1;
                answer_next = 1'b1;
                count_next  = count_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        ctl.sample = accept;
        ctl.add    = finish && do_add;
        ctl.remove = finish && do_remove;
        ctl.slot   = slot;
        ctl.count  = count_reg;
        ctl.bank   = accept ? req.bank : bank_reg;
        ctl.tile   = accept ? req.tile : tile_reg;
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        if (g == MAX_ENTRIES - 1)
        begin : g_last
            spt_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .idx     (IDX_W'(g)),
                .ctl     (ctl),
                .nb_bank (cell_bank[g]),
                .nb_tile (cell_tile[g]),
                .bank    (cell_bank[g]),
                .tile    (cell_tile[g]),
                .hit     (hit_vec[g])
            );
        end
        else
        begin : g_mid
            spt_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .idx     (IDX_W'(g)),
                .ctl     (ctl),
                .nb_bank (cell_bank[g+1]),
                .nb_tile (cell_tile[g+1]),
                .bank    (cell_bank[g]),
                .tile    (cell_tile[g]),
                .hit     (hit_vec[g])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
            if (finish)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the request and the response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= req.operation;
            pair_ok_reg <= pair_ok;
            bank_reg    <= req.bank;
            tile_reg    <= req.tile;
        end
        if (finish)
        begin
            answer_reg <= answer_next;
            reject_reg <= reject_next;
            entry_reg  <= ENTRY_W'(count_next);
        end
    end

    assign req.ready       = !busy_reg;
    assign rsp.valid       = out_valid_reg;
    assign rsp.answer      = answer_reg;
    assign rsp.full_reject = reject_reg;
    assign rsp.entry_count = entry_reg;

    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> $onehot0(hit_vec))
        else $error("more than one cell holds the same pair");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("pair count above capacity");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("second request taken while one is in flight");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && reject_next) |-> (count_reg == CNT_W'(MAX_ENTRIES) && !answer_next))
        else $error("add refused while the set has room");
endmodule

/* tb/tb.sv */
module tb;
    import spt_pkg::*;

    typedef struct packed {
        logic               answer;
        logic               full_reject;
        logic [ENTRY_W-1:0] entry_count;
    } spt_result_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        bank_t           bank;
        tile_t           tile;
        logic            known;
        spt_result_t     want;
    } directed_step_t;

    localparam int N_DIRECTED = 21;
    localparam int GAP_PCT    = 23;
    localparam int N_RANDOM   = 1500;

    logic clk;
    logic rst_n;
    logic no_gaps;

    spt_req_if req_bus ();
    spt_rsp_if rsp_bus ();

    solid_pattern_set_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Shadow copy of the solid set
    bank_t held_bank [MAX_ENTRIES];
    tile_t held_tile [MAX_ENTRIES];
    int    held_count;

    spt_result_t pending_rsp [$];
    // One note per request; directed entries may carry typed-in answers
    directed_step_t table_notes [$];

    int error_count;
    int rsp_count;
    int n_query, n_set, n_clear, n_toggle, n_bad_pair, n_refused, peak_count;

    initial begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

    // Apply one request to the shadow set and return the expected response
    function automatic spt_result_t solid_table_update(logic [OP_W-1:0] op, bank_t bank,
                                                       tile_t tile);
        spt_result_t r;
        int          slot;
        logic        want_on;
        r    = '0;
        slot = -1;
        if (bank < NUM_BANKS && tile < TILES_PER_BANK) begin
            for (int i = 0; i < held_count; i++) begin
                if (slot < 0 && held_bank[i] == bank && held_tile[i] == tile)
                begin
                    slot = i;
                end
            end
            if (op == OP_QUERY) begin
                r.answer = (slot >= 0);
            end
            else begin
                case (op)
                    OP_SET:   want_on = 1'b1;
                    OP_CLEAR: want_on = 1'b0;
                    default:  want_on = (slot < 0);
                endcase
                if (slot >= 0) begin
                    if (want_on) begin
                        r.answer = 1'b1;
                    end
                    else begin
                        // fill the hole with the last entry
                        held_bank[slot] = held_bank[held_count-1];
                        held_tile[slot] = held_tile[held_count-1];
                        held_count--;
                    end
                end
                else if (want_on) begin
                    if (held_count >= MAX_ENTRIES) begin
                        r.full_reject = 1'b1;
                    end
                    else begin
                        held_bank[held_count] = bank;
                        held_tile[held_count] = tile;
                        held_count++;
                        r.answer = 1'b1;
                    end
                end
            end
        end
        r.entry_count = ENTRY_W'(held_count);
        return r;
    endfunction

    task automatic compare_result(spt_result_t want, spt_result_t got);
        if (got !== want) begin
            error_count++;
            // keep the log bounded on a badly broken block
            if (error_count <= 60) begin
                if (got.answer !== want.answer)
                    $error("answer: expected %0d, actual %0d", want.answer, got.answer);
                if (got.full_reject !== want.full_reject)
                    $error("full_reject: expected %0d, actual %0d",
                           want.full_reject, got.full_reject);
                if (got.entry_count !== want.entry_count)
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, got.entry_count);
            end
        end
    endtask

    always @(posedge clk) begin
        spt_result_t got;
        spt_result_t predicted;
        directed_step_t note;
        if (rst_n) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                got.answer      = rsp_bus.answer;
                got.full_reject = rsp_bus.full_reject;
                got.entry_count = rsp_bus.entry_count;
                rsp_count++;
                if (pending_rsp.size() == 0) begin
                    error_count++;
                    $error("response transaction with no request outstanding");
                end
                else begin
                    compare_result(pending_rsp.pop_front(), got);
                end
            end
            if (req_bus.valid && req_bus.ready) begin
                predicted = solid_table_update(req_bus.operation, req_bus.bank, req_bus.tile);
                note = table_notes.pop_front();
                pending_rsp.push_back(note.known ? note.want : predicted);
                case (req_bus.operation)
                    OP_QUERY: n_query++;
                    OP_SET:   n_set++;
                    OP_CLEAR: n_clear++;
                    default:  n_toggle++;
                endcase
                if (req_bus.bank >= NUM_BANKS || req_bus.tile >= TILES_PER_BANK)
                    n_bad_pair++;
                if (predicted.full_reject)
                    n_refused++;
                if (held_count > peak_count)
                    peak_count = held_count;
            end
        end
    end

    // Response side back-pressure
    always @(negedge clk) begin
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else
            rsp_bus.ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PCT);
    end

    task automatic send_request(logic [OP_W-1:0] op, bank_t bank, tile_t tile,
                                logic known, spt_result_t want);
        directed_step_t note;
        note.op    = op;
        note.bank  = bank;
        note.tile  = tile;
        note.known = known;
        note.want  = want;
        @(negedge clk);
        while (!no_gaps && $urandom_range(0, 99) < GAP_PCT) begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.operation <= op;
        req_bus.bank      <= bank;
        req_bus.tile      <= tile;
        table_notes.push_back(note);
        do @(posedge clk); while (!req_bus.ready);
    endtask

    initial begin
        directed_step_t directed_steps [N_DIRECTED];
        bank_t          pool_bank [400];
        tile_t          pool_tile [400];
        int             pool_n;
        int             mix;
        int             ep_len;
        int             pick;
        int             r;
        int             sent;
        int             base;
        int             key;
        logic [OP_W-1:0] op;

        rst_n             = 1'b0;
        no_gaps           = 1'b0;
        req_bus.valid     = 1'b0;
        req_bus.operation = OP_QUERY;
        req_bus.bank      = '0;
        req_bus.tile      = '0;
        held_count        = 0;
        error_count       = 0;
        rsp_count         = 0;
        n_query           = 0;
        n_set             = 0;
        n_clear           = 0;
        n_toggle          = 0;
        n_bad_pair        = 0;
        n_refused         = 0;
        peak_count        = 0;

        directed_steps = '{
            '{OP_QUERY,  8'd0,   8'd0,   1'b1, '{1'b0, 1'b0, 7'd0}},
            '{OP_CLEAR,  8'd0,   8'd0,   1'b1, '{1'b0, 1'b0, 7'd0}},
            '{OP_SET,    8'd0,   8'd0,   1'b1, '{1'b1, 1'b0, 7'd1}},
            '{OP_SET,    8'd0,   8'd0,   1'b1, '{1'b1, 1'b0, 7'd1}},
            '{OP_QUERY,  8'd0,   8'd0,   1'b1, '{1'b1, 1'b0, 7'd1}},
            '{OP_SET,    8'd3,   8'd255, 1'b1, '{1'b1, 1'b0, 7'd2}},
            '{OP_SET,    8'd4,   8'd0,   1'b1, '{1'b0, 1'b0, 7'd2}},
            '{OP_QUERY,  8'd255, 8'd255, 1'b1, '{1'b0, 1'b0, 7'd2}},
            '{OP_TOGGLE, 8'd128, 8'd1,   1'b1, '{1'b0, 1'b0, 7'd2}},
            '{OP_CLEAR,  8'd7,   8'd0,   1'b1, '{1'b0, 1'b0, 7'd2}},
            '{OP_CLEAR,  8'd1,   8'd7,   1'b1, '{1'b0, 1'b0, 7'd2}},
            '{OP_TOGGLE, 8'd2,   8'd128, 1'b1, '{1'b1, 1'b0, 7'd3}},
            '{OP_TOGGLE, 8'd2,   8'd128, 1'b1, '{1'b0, 1'b0, 7'd2}},
            '{OP_SET,    8'd1,   8'd170, 1'b0, '0},
            '{OP_SET,    8'd2,   8'd85,  1'b0, '0},
            '{OP_CLEAR,  8'd0,   8'd0,   1'b0, '0},
            '{OP_QUERY,  8'd2,   8'd85,  1'b0, '0},
            '{OP_QUERY,  8'd0,   8'd0,   1'b0, '0},
            '{OP_CLEAR,  8'd2,   8'd85,  1'b0, '0},
            '{OP_QUERY,  8'd3,   8'd255, 1'b0, '0},
            '{OP_QUERY,  8'd1,   8'd170, 1'b0, '0}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_steps[i])
            send_request(directed_steps[i].op, directed_steps[i].bank,
                         directed_steps[i].tile, directed_steps[i].known,
                         directed_steps[i].want);

        // Fill past capacity with distinct pairs so adds get refused
        sent = 0;
        base = $urandom_range(0, 1023);
        for (int i = 0; i < 72; i++) begin
            key = (base + i * 7) % 1024;
            op  = $urandom_range(0, 1) ? OP_SET : OP_TOGGLE;
            send_request(op, bank_t'(key / 256), tile_t'(key % 256), 1'b0, '0);
            sent++;
        end

        // Episodes over a small pool of pairs, with varying add/remove bias
        while (sent < N_RANDOM) begin
            case ($urandom_range(0, 4))
                0:       pool_n = 3;
                1:       pool_n = 12;
                2:       pool_n = 48;
                3:       pool_n = 90;
                default: pool_n = 400;
            endcase
            for (int i = 0; i < pool_n; i++) begin
                pool_bank[i] = bank_t'($urandom_range(0, NUM_BANKS - 1));
                pool_tile[i] = tile_t'($urandom_range(0, TILES_PER_BANK - 1));
            end
            mix    = $urandom_range(0, 2);
            ep_len = $urandom_range(40, 120);
            for (int n = 0; n < ep_len; n++) begin
                no_gaps = (sent >= 500 && sent < 800);
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    send_request(OP_W'($urandom_range(0, 3)), bank_t'($urandom_range(0, 255)),
                                 tile_t'($urandom_range(0, 255)), 1'b0, '0);
                end
                else begin
                    pick = $urandom_range(0, pool_n - 1);
                    r    = $urandom_range(0, 99);
                    case (mix)
                        0:       op = (r < 15) ? OP_QUERY : (r < 60) ? OP_SET :
                                      (r < 70) ? OP_CLEAR : OP_TOGGLE;
                        1:       op = (r < 15) ? OP_QUERY : (r < 25) ? OP_SET :
                                      (r < 70) ? OP_CLEAR : OP_TOGGLE;
                        default: op = (r < 25) ? OP_QUERY : (r < 50) ? OP_SET :
                                      (r < 75) ? OP_CLEAR : OP_TOGGLE;
                    endcase
                    send_request(op, pool_bank[pick], pool_tile[pick], 1'b0, '0);
                end
                sent++;
            end
        end
        no_gaps = 1'b0;

        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d requests (%0d query, %0d set, %0d clear, %0d toggle), %0d responses.",
                 n_query + n_set + n_clear + n_toggle, n_query, n_set, n_clear, n_toggle,
                 rsp_count);
        $display("Out-of-range pairs: %0d, refused adds: %0d, peak list size: %0d.",
                 n_bad_pair, n_refused, peak_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
